@@ hdl/adjacency_matrix_graph_store_core_defines.svh @@
// Assertion macros for the adjacency matrix graph store.
// Taken in by the top level through an include; depends on nothing else.
`ifndef ADJACENCY_MATRIX_GRAPH_STORE_CORE_DEFINES_SVH
`define ADJACENCY_MATRIX_GRAPH_STORE_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define AMG_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define AMG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hdl/amg_pkg.sv @@
// Shared codes for the adjacency matrix graph store: request modes and result kinds.
// Depends on nothing.
`default_nettype none
package amg_pkg;
    localparam int ID_BITS   = 16;
    localparam int MODE_BITS = 3;
    localparam int KIND_BITS = 3;
    localparam int DEG_BITS  = 5;

    localparam logic [MODE_BITS-1:0] MODE_ADD_VERTEX = 3'd0;
    localparam logic [MODE_BITS-1:0] MODE_ADD_EDGE   = 3'd1;
    localparam logic [MODE_BITS-1:0] MODE_DEL_VERTEX = 3'd2;
    localparam logic [MODE_BITS-1:0] MODE_DEL_EDGE   = 3'd3;
    localparam logic [MODE_BITS-1:0] MODE_ADJ_QUERY  = 3'd4;
    localparam logic [MODE_BITS-1:0] MODE_MIN_QUERY  = 3'd5;

    localparam logic [KIND_BITS-1:0] KIND_EXISTS  = 3'd0;
    localparam logic [KIND_BITS-1:0] KIND_NONE    = 3'd1;
    localparam logic [KIND_BITS-1:0] KIND_ADJ     = 3'd2;
    localparam logic [KIND_BITS-1:0] KIND_MIN     = 3'd3;
    localparam logic [KIND_BITS-1:0] KIND_EMPTY   = 3'd4;
    localparam logic [KIND_BITS-1:0] KIND_UNKNOWN = 3'd5;
    localparam logic [KIND_BITS-1:0] KIND_FULL    = 3'd6;
endpackage
`default_nettype wire

@@ hdl/amg_if.sv @@
// Valid/ready channel interfaces for requests and results of the graph store.
// Depends on amg_pkg for field widths.
`default_nettype none
interface amg_req_if;
    logic                             valid;
    logic                             ready;
    logic [amg_pkg::MODE_BITS-1:0]    mode;
    logic [amg_pkg::ID_BITS-1:0]      first_id;
    logic [amg_pkg::ID_BITS-1:0]      second_id;
    modport source (output valid, mode, first_id, second_id, input ready);
    modport sink   (input valid, mode, first_id, second_id, output ready);
endinterface

interface amg_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [amg_pkg::KIND_BITS-1:0]    kind;
    logic                             adjacent;
    logic [amg_pkg::ID_BITS-1:0]      answer_id;
    logic [amg_pkg::DEG_BITS-1:0]     degree;
    modport source (output valid, kind, adjacent, answer_id, degree, input ready);
    modport sink   (input valid, kind, adjacent, answer_id, degree, output ready);
endinterface
`default_nettype wire

@@ hdl/amg_cell.sv @@
// One slot of the graph store ring: valid mark, vertex id and adjacency row.
// Depends on nothing; instantiated by the top level.
`default_nettype none
module amg_cell #(
    parameter int N   = 32,
    parameter int IDW = 16
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_shift,
    input  wire logic           i_valid,
    input  wire logic [IDW-1:0] i_id,
    input  wire logic [N-1:0]   i_row,
    output logic                o_valid,
    output logic [IDW-1:0]      o_id,
    output logic [N-1:0]        o_row
);
    logic           r_valid;
    logic [IDW-1:0] r_id;
    logic [N-1:0]   r_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_row   <= '0;
        end else if (i_shift) begin
            r_valid <= i_valid;
            r_row   <= i_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_id <= i_id;
        end
    end

    assign o_valid = r_valid;
    assign o_id    = r_id;
    assign o_row   = r_row;
endmodule
`default_nettype wire

@@ hdl/adjacency_matrix_graph_store_core.sv @@
// Channel    Dir  Fields                                   Beat when
// i_req      in   mode, first_id, second_id                valid && ready
// o_rsp      out  kind, adjacent, answer_id, degree        valid && ready
//
// Each request turns the ring of slot cells once to search, and once more to write when
// it changes the graph.
// Reset is synchronous and active low; it clears every valid mark and adjacency row.
// A result waits in the output register; a new request is taken while it waits.
// A stalled result holds the block in its answer state until the beat goes out.
// Depends on amg_pkg, amg_if, amg_cell and the defines header.
`default_nettype none
`include "adjacency_matrix_graph_store_core_defines.svh"
module adjacency_matrix_graph_store_core #(
    parameter int MAX_VERTICES = 32,
    parameter int ID_WIDTH     = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    amg_req_if.sink    i_req,
    amg_rsp_if.source  o_rsp
);
    localparam int N  = MAX_VERTICES;
    localparam int SW = (N > 1) ? $clog2(N) : 1;
    localparam int DW = $clog2(N + 1);
    localparam logic [SW-1:0] LAST   = SW'(N - 1);
    localparam logic [N-1:0]  ONEHOT = {{(N-1){1'b0}}, 1'b1};

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_EVAL, S_RESP, S_APPLY} t_state;

    t_state r_state;
    logic [SW-1:0] r_cnt;

    // Latched request.
    logic [amg_pkg::MODE_BITS-1:0] r_mode;
    logic [ID_WIDTH-1:0] r_a, r_b;

    // Search results gathered while the ring turns once.
    logic r_fa, r_fb, r_ff, r_fm;
    logic [SW-1:0] r_sa, r_sb, r_sf, r_sm, r_ta;
    logic [N-1:0] r_row_a, r_row_b, r_row_m;
    logic [ID_WIDTH-1:0] r_min_id;
    logic [DW-1:0] r_deg_a, r_deg_b, r_deg_m;

    // Output register.
    logic r_out_valid;
    logic [amg_pkg::KIND_BITS-1:0] r_kind;
    logic r_adj;
    logic [amg_pkg::ID_BITS-1:0] r_ans;
    logic [amg_pkg::DEG_BITS-1:0] r_deg;

    // Ring of cells; cell 0 is the head the controller looks at.
    logic w_valid [N];
    logic [ID_WIDTH-1:0] w_id [N];
    logic [N-1:0] w_row [N];
    logic n_valid;
    logic [ID_WIDTH-1:0] n_id;
    logic [N-1:0] n_row;
    logic w_shift;

    assign w_shift = (r_state == S_SCAN) || (r_state == S_APPLY);

    for (genvar j = 0; j < N; j++) begin : g_cell
        if (j == N - 1) begin : g_tail
            amg_cell #(.N(N), .IDW(ID_WIDTH)) u_cell (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_shift(w_shift),
                .i_valid(n_valid), .i_id(n_id), .i_row(n_row),
                .o_valid(w_valid[j]), .o_id(w_id[j]), .o_row(w_row[j])
            );
        end else begin : g_body
            amg_cell #(.N(N), .IDW(ID_WIDTH)) u_cell (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_shift(w_shift),
                .i_valid(w_valid[j+1]), .i_id(w_id[j+1]), .i_row(w_row[j+1]),
                .o_valid(w_valid[j]), .o_id(w_id[j]), .o_row(w_row[j])
            );
        end
    end

    // The head slot passes to the tail, edited during the write pass.
    // r_cnt is the slot number of the row currently at the head.
    always_comb begin
        n_valid = w_valid[0];
        n_id    = w_id[0];
        n_row   = w_row[0];
        if (r_state == S_APPLY) begin
            case (r_mode)
                amg_pkg::MODE_ADD_VERTEX: begin
                    n_row[r_ta] = 1'b0;
                    if (r_cnt == r_ta) begin
                        n_valid = 1'b1;
                        n_id    = r_a;
                        n_row   = '0;
                    end
                end
                amg_pkg::MODE_DEL_VERTEX: begin
                    n_row[r_ta] = 1'b0;
                    if (r_cnt == r_ta) begin
                        n_valid = 1'b0;
                        n_row   = '0;
                    end
                end
                amg_pkg::MODE_ADD_EDGE, amg_pkg::MODE_DEL_EDGE: begin
                    if (r_cnt == r_sa) begin
                        n_row[r_sb] = (r_mode == amg_pkg::MODE_ADD_EDGE);
                    end
                    if (r_cnt == r_sb) begin
                        n_row[r_sa] = (r_mode == amg_pkg::MODE_ADD_EDGE);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Answer formation for the response state.
    logic w_emit, w_apply;
    logic [amg_pkg::KIND_BITS-1:0] w_kind;
    logic w_adj;
    logic [ID_WIDTH-1:0] w_pick;
    logic [amg_pkg::ID_BITS-1:0] w_ans;
    logic [amg_pkg::DEG_BITS-1:0] w_deg;

    always_comb begin
        w_emit  = 1'b0;
        w_apply = 1'b0;
        w_kind  = amg_pkg::KIND_EXISTS;
        w_adj   = 1'b0;
        w_ans   = '0;
        w_deg   = '0;
        if (r_deg_a > r_deg_b) begin
            w_pick = r_b;
        end else if (r_deg_a < r_deg_b) begin
            w_pick = r_a;
        end else begin
            w_pick = (r_a > r_b) ? r_b : r_a;
        end
        unique case (r_mode)
            amg_pkg::MODE_ADD_VERTEX: begin
                if (r_fa) begin
                    w_emit = 1'b1;
                    w_kind = amg_pkg::KIND_EXISTS;
                end else if (!r_ff) begin
                    w_emit = 1'b1;
                    w_kind = amg_pkg::KIND_FULL;
                end else begin
                    w_apply = 1'b1;
                end
            end
            amg_pkg::MODE_ADD_EDGE, amg_pkg::MODE_DEL_EDGE: begin
                if (!r_fa || !r_fb) begin
                    w_emit = 1'b1;
                    w_kind = amg_pkg::KIND_UNKNOWN;
                end else if (r_row_a[r_sb] && (r_mode == amg_pkg::MODE_ADD_EDGE)) begin
                    w_emit = 1'b1;
                    w_kind = amg_pkg::KIND_EXISTS;
                end else if (!r_row_a[r_sb] && (r_mode == amg_pkg::MODE_DEL_EDGE)) begin
                    w_emit = 1'b1;
                    w_kind = amg_pkg::KIND_NONE;
                end else begin
                    w_apply = 1'b1;
                end
            end
            amg_pkg::MODE_DEL_VERTEX: begin
                if (!r_fa) begin
                    w_emit = 1'b1;
                    w_kind = amg_pkg::KIND_UNKNOWN;
                end else begin
                    w_apply = 1'b1;
                end
            end
            amg_pkg::MODE_ADJ_QUERY: begin
                w_emit = 1'b1;
                if (!r_fa || !r_fb) begin
                    w_kind = amg_pkg::KIND_UNKNOWN;
                end else begin
                    w_kind = amg_pkg::KIND_ADJ;
                    w_adj  = r_row_a[r_sb];
                    w_ans  = amg_pkg::ID_BITS'(w_pick);
                end
            end
            amg_pkg::MODE_MIN_QUERY: begin
                w_emit = 1'b1;
                if (!r_fm) begin
                    w_kind = amg_pkg::KIND_EMPTY;
                end else begin
                    w_kind = amg_pkg::KIND_MIN;
                    w_ans  = amg_pkg::ID_BITS'(r_min_id);
                    w_deg  = (32'(r_deg_m) > 32'd31) ? 5'd31 : amg_pkg::DEG_BITS'(r_deg_m);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // A beat that leaves while a new result is loaded is replaced below.
            if (r_out_valid && o_rsp.ready && !((r_state == S_RESP) && w_emit)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_mode  <= i_req.mode;
                        r_a     <= ID_WIDTH'(i_req.first_id);
                        r_b     <= ID_WIDTH'(i_req.second_id);
                        r_fa    <= 1'b0;
                        r_fb    <= 1'b0;
                        r_ff    <= 1'b0;
                        r_fm    <= 1'b0;
                        r_cnt   <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // Look at the slot at the head as the ring turns.
                    if (w_valid[0] && (w_id[0] == r_a) && !r_fa) begin
                        r_fa    <= 1'b1;
                        r_sa    <= r_cnt;
                        r_row_a <= w_row[0];
                    end
                    if (w_valid[0] && (w_id[0] == r_b) && !r_fb) begin
                        r_fb    <= 1'b1;
                        r_sb    <= r_cnt;
                        r_row_b <= w_row[0];
                    end
                    if (!w_valid[0] && !r_ff) begin
                        r_ff <= 1'b1;
                        r_sf <= r_cnt;
                    end
                    if (w_valid[0] && (!r_fm || (w_id[0] < r_min_id))) begin
                        r_fm     <= 1'b1;
                        r_sm     <= r_cnt;
                        r_min_id <= w_id[0];
                        r_row_m  <= w_row[0];
                    end
                    if (r_cnt == LAST) begin
                        r_cnt   <= '0;
                        r_state <= S_EVAL;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_EVAL: begin
                    // Degrees leave out the self-loop bit.
                    r_deg_a <= DW'($countones(r_row_a & ~(ONEHOT << r_sa)));
                    r_deg_b <= DW'($countones(r_row_b & ~(ONEHOT << r_sb)));
                    r_deg_m <= DW'($countones(r_row_m & ~(ONEHOT << r_sm)));
                    r_ta    <= (r_mode == amg_pkg::MODE_ADD_VERTEX) ? r_sf : r_sa;
                    r_state <= S_RESP;
                end
                S_RESP: begin
                    if (w_emit) begin
                        if (!r_out_valid || o_rsp.ready) begin
                            r_out_valid <= 1'b1;
                            r_kind      <= w_kind;
                            r_adj       <= w_adj;
                            r_ans       <= w_ans;
                            r_deg       <= w_deg;
                            r_state     <= S_IDLE;
                        end
                    end else if (w_apply) begin
                        r_cnt   <= '0;
                        r_state <= S_APPLY;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_APPLY: begin
                    if (r_cnt == LAST) begin
                        r_cnt   <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready     = (r_state == S_IDLE);
    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.kind      = r_kind;
    assign o_rsp.adjacent  = r_adj;
    assign o_rsp.answer_id = r_ans;
    assign o_rsp.degree    = r_deg;

    // A taken request starts a fresh pass from slot zero.
    `AMG_ASSERT_NEXT(a_start_scan, i_clk, i_rst_n, i_req.valid && i_req.ready, (r_state == S_SCAN) && (r_cnt == '0))
    // Each ring pass ends with the ring back in its home position.
    `AMG_ASSERT_NEXT(a_pass_wrap, i_clk, i_rst_n, w_shift && (r_cnt == LAST), r_cnt == '0)
    // A pending result is never dropped while the sink stalls.
    `AMG_ASSERT_NEXT(a_hold_out, i_clk, i_rst_n, r_out_valid && !o_rsp.ready, r_out_valid && $stable(r_kind) && $stable(r_ans))
endmodule
`default_nettype wire
